@@ rtl/segi_pkg.sv @@
// ----------------------------------------------------------------------------
// segi_pkg
// Types and constants shared by the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

	// Defaults for the top level parameters
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	// Fixed field widths of the words
	localparam int IN_W     = 16;
	localparam int OUT_W    = 24;
	localparam int QUO_BITS = OUT_W + 1;
	localparam int OUT_MAX  = (2 ** (OUT_W - 1)) - 1;

	// Result classification
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_GEN  = 2'd1,
		KIND_COL  = 2'd2
	} kind_t;

	// Sign of a cross product
	typedef enum logic [1:0] {
		ORI_COL = 2'd0,
		ORI_POS = 2'd1,
		ORI_NEG = 2'd2
	} ori_t;

	typedef struct packed {
		logic signed [IN_W-1:0] first_start_x;
		logic signed [IN_W-1:0] first_start_y;
		logic signed [IN_W-1:0] first_end_x;
		logic signed [IN_W-1:0] first_end_y;
		logic signed [IN_W-1:0] second_start_x;
		logic signed [IN_W-1:0] second_start_y;
		logic signed [IN_W-1:0] second_end_x;
		logic signed [IN_W-1:0] second_end_y;
	} seg_t;

	typedef struct packed {
		logic                    hit;
		kind_t                   hit_kind;
		logic signed [OUT_W-1:0] point_x;
		logic signed [OUT_W-1:0] point_y;
	} res_t;

	// Control travelling with a division
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic use_div;
		res_t side;
	} div_ctl_t;

endpackage

@@ rtl/segi_div.sv @@
// ----------------------------------------------------------------------------
// segi_div
// Pipelined restoring divider: two numerators over one denominator, one
// quotient bit per stage, saturated to the signed output range.
// ----------------------------------------------------------------------------
module segi_div #(
	parameter int RW = 64,
	parameter int DW = 35
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ent_valid,
	output logic                 ent_stall,
	input  logic [RW-1:0]        num_x,
	input  logic [RW-1:0]        num_y,
	input  logic [DW-1:0]        den,
	input  segi_pkg::div_ctl_t   ctl,
	output logic                 res_valid,
	input  logic                 res_stall,
	output segi_pkg::res_t       res
);

	localparam int QB = segi_pkg::QUO_BITS;
	localparam int OW = segi_pkg::OUT_W;

	logic               v   [QB+2];
	logic               adv [QB+2];
	logic [RW-1:0]      rx  [QB+1];
	logic [RW-1:0]      ry  [QB+1];
	logic [DW-1:0]      d   [QB+1];
	logic [QB-1:0]      qx  [QB+1];
	logic [QB-1:0]      qy  [QB+1];
	logic               ox  [QB+1];
	logic               oy  [QB+1];
	segi_pkg::div_ctl_t c   [QB+1];
	segi_pkg::res_t     res_c;

	// Saturate a quotient magnitude to the signed output range
	function automatic logic [OW-1:0] sat(input logic [QB-1:0] q, input logic ovf,
			input logic neg);
		logic [OW-1:0] m;
		m = q[OW-1:0];
		if (neg) begin
			if (ovf || q > QB'(segi_pkg::OUT_MAX + 1))
				return {1'b1, {(OW-1){1'b0}}};
			return OW'(-m);
		end
		if (ovf || q > QB'(segi_pkg::OUT_MAX))
			return {1'b0, {(OW-1){1'b1}}};
		return m;
	endfunction

	// Advance chain: a stage loads when empty or when the next one moves
	always_comb begin
		adv[QB+1] = !v[QB+1] || !res_stall;
		for (int k = QB; k >= 0; k--) begin
			adv[k] = !v[k] || adv[k+1];
		end
	end

	assign ent_stall = !adv[0];

	// Entry stage: overflow when the quotient needs more than QB bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (adv[0]) begin
			v[0] <= ent_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && ent_valid) begin
			rx[0] <= num_x;
			ry[0] <= num_y;
			d[0]  <= den;
			qx[0] <= '0;
			qy[0] <= '0;
			ox[0] <= num_x >= (RW'(den) << QB);
			oy[0] <= num_y >= (RW'(den) << QB);
			c[0]  <= ctl;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 1; k <= QB; k++) begin : g_bit
		localparam int SH = QB - k;
		logic [RW-1:0] ds;
		logic          bx, by;

		assign ds = RW'(d[k-1]) << SH;
		assign bx = rx[k-1] >= ds;
		assign by = ry[k-1] >= ds;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[k] <= 1'b0;
			end else if (adv[k]) begin
				v[k] <= v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && v[k-1]) begin
				rx[k] <= bx ? rx[k-1] - ds : rx[k-1];
				ry[k] <= by ? ry[k-1] - ds : ry[k-1];
				qx[k] <= {qx[k-1][QB-2:0], bx};
				qy[k] <= {qy[k-1][QB-2:0], by};
				d[k]  <= d[k-1];
				ox[k] <= ox[k-1];
				oy[k] <= oy[k-1];
				c[k]  <= c[k-1];
			end
		end
	end

	// Output stage: saturate and select against the side result
	always_comb begin
		res_c = c[QB].side;
		if (c[QB].use_div) begin
			res_c.point_x = sat(qx[QB], ox[QB], c[QB].neg_x);
			res_c.point_y = sat(qy[QB], oy[QB], c[QB].neg_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[QB+1] <= 1'b0;
		end else if (adv[QB+1]) begin
			v[QB+1] <= v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[QB+1] && v[QB]) begin
			res <= res_c;
		end
	end

	assign res_valid = v[QB+1];

endmodule

@@ rtl/segment_intersection_top.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_top
// Segment pair intersection test with fixed point crossing point.
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle while seg_stall is low and returns one result
// word per pair, in order, after 7 front stages and the 25-bit pipelined divider
// (27 stages). Throughput is one word per cycle when the output is not stalled;
// every stage holds one word and fills bubbles while the output is stalled.
// Orientation signs and the determinant come from full products; the Cramer
// numerators use split multiplies; the quotient is produced one bit per stage.
module segment_intersection_top #(
	parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           seg_valid,
	output logic           seg_stall,
	input  segi_pkg::seg_t seg,
	output logic           res_valid,
	input  logic           res_stall,
	output segi_pkg::res_t res
);

	localparam int CB    = COORD_BITS;
	localparam int F     = FRAC_BITS;
	localparam int IN_W  = segi_pkg::IN_W;
	localparam int OUT_W = segi_pkg::OUT_W;
	localparam int WX    = (CB > IN_W) ? CB : IN_W;
	localparam int DFW   = CB + 1;
	localparam int PW    = 2 * DFW;
	localparam int OW    = PW + 1;
	localparam int CCW   = 2 * CB + 2;
	localparam int DTW   = 2 * CB + 3;
	localparam int L     = CCW / 2;
	localparam int PPW   = DFW + L + 1;
	localparam int NPW   = 3 * CB + 4;
	localparam int NW    = NPW + F;
	localparam int QB    = segi_pkg::QUO_BITS;
	localparam int RW    = (NW > DTW + QB) ? NW : DTW + QB;
	localparam int EW    = (CB + F + 1 > OUT_W + 1) ? CB + F + 1 : OUT_W + 1;
	localparam logic signed [EW-1:0] SMAX = EW'(segi_pkg::OUT_MAX);
	localparam logic signed [EW-1:0] SMIN = EW'(-segi_pkg::OUT_MAX - 1);

	// Low COORD_BITS of a field, zero extended when COORD_BITS exceeds the field
	function automatic logic signed [CB-1:0] grab(input logic [IN_W-1:0] f);
		logic [WX-1:0] z;
		z = WX'(f);
		return z[CB-1:0];
	endfunction

	function automatic logic signed [DFW-1:0] dif(input logic signed [CB-1:0] a,
			input logic signed [CB-1:0] b);
		return DFW'(a) - DFW'(b);
	endfunction

	// q inside the box spanned by p and r
	function automatic logic onseg(input logic signed [CB-1:0] px,
			input logic signed [CB-1:0] py, input logic signed [CB-1:0] qx,
			input logic signed [CB-1:0] qy, input logic signed [CB-1:0] rx,
			input logic signed [CB-1:0] ry);
		return ((qx <= px) || (qx <= rx)) && ((qx >= px) || (qx >= rx)) &&
			((qy <= py) || (qy <= ry)) && ((qy >= py) || (qy >= ry));
	endfunction

	function automatic segi_pkg::ori_t ori(input logic signed [OW-1:0] v);
		if (v == '0)
			return segi_pkg::ORI_COL;
		return v[OW-1] ? segi_pkg::ORI_NEG : segi_pkg::ORI_POS;
	endfunction

	function automatic logic signed [OUT_W-1:0] scale_sat(
			input logic signed [CB-1:0] v);
		logic signed [EW-1:0] s;
		s = EW'(v);
		s = s <<< F;
		if (s > SMAX)
			return SMAX[OUT_W-1:0];
		if (s < SMIN)
			return SMIN[OUT_W-1:0];
		return s[OUT_W-1:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;
	logic div_stall;

	// Coordinates: x1,y1,x2,y2,x3,y3,x4,y4
	logic signed [CB-1:0]  crd_s1 [8];
	logic signed [CB-1:0]  crd_s2 [8];
	logic signed [CB-1:0]  crd_s3 [8];
	logic signed [PW-1:0]  op_c   [8];
	logic signed [PW-1:0]  op_s2  [8];
	logic signed [DFW-1:0] ab_c   [4];
	logic signed [DFW-1:0] ab_s2  [4];
	logic signed [DFW-1:0] ab_s3  [4];
	logic signed [PW-1:0]  cp_c   [4];
	logic signed [PW-1:0]  cp_s2  [4];
	logic signed [PW-1:0]  dp_c   [2];
	logic signed [PW-1:0]  dp_s2  [2];
	logic                  on_c   [4];
	logic                  on_s2  [4];
	logic                  on_s3  [4];
	segi_pkg::ori_t        ori_s3 [4];
	logic signed [CCW-1:0] c1_s3, c2_s3;
	logic signed [DTW-1:0] det_s3, det_s4, det_s5, det_s6;
	logic signed [PPW-1:0] pp_c   [8];
	logic signed [PPW-1:0] pp_s4  [8];
	logic                  gen_c, gen_s4, gen_s5, gen_s6;
	segi_pkg::res_t        side_c, side_s4, side_s5, side_s6;
	logic signed [NPW-1:0] fp_s5  [4];
	logic signed [NW-1:0]  nx_s6, ny_s6;
	logic [NW-1:0]         mx_c, my_c;
	logic [DTW-1:0]        md_c;
	logic [RW-1:0]         mx_s7, my_s7;
	logic [DTW-1:0]        md_s7;
	segi_pkg::div_ctl_t    ctl_s7;

	// Advance chain over the front stages
	assign adv_s7    = !v_s7 || !div_stall;
	assign adv_s6    = !v_s6 || adv_s7;
	assign adv_s5    = !v_s5 || adv_s6;
	assign adv_s4    = !v_s4 || adv_s5;
	assign adv_s3    = !v_s3 || adv_s4;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign seg_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= seg_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
		end
	end

	// Stage 1: capture the low COORD_BITS of each coordinate
	always_ff @(posedge clk) begin
		if (adv_s1 && seg_valid) begin
			crd_s1[0] <= grab(seg.first_start_x);
			crd_s1[1] <= grab(seg.first_start_y);
			crd_s1[2] <= grab(seg.first_end_x);
			crd_s1[3] <= grab(seg.first_end_y);
			crd_s1[4] <= grab(seg.second_start_x);
			crd_s1[5] <= grab(seg.second_start_y);
			crd_s1[6] <= grab(seg.second_end_x);
			crd_s1[7] <= grab(seg.second_end_y);
		end
	end

	// Stage 2: differences and products, bounding box tests
	always_comb begin
		op_c[0] = dif(crd_s1[3], crd_s1[1]) * dif(crd_s1[4], crd_s1[2]);
		op_c[1] = dif(crd_s1[2], crd_s1[0]) * dif(crd_s1[5], crd_s1[3]);
		op_c[2] = dif(crd_s1[3], crd_s1[1]) * dif(crd_s1[6], crd_s1[2]);
		op_c[3] = dif(crd_s1[2], crd_s1[0]) * dif(crd_s1[7], crd_s1[3]);
		op_c[4] = dif(crd_s1[7], crd_s1[5]) * dif(crd_s1[0], crd_s1[6]);
		op_c[5] = dif(crd_s1[6], crd_s1[4]) * dif(crd_s1[1], crd_s1[7]);
		op_c[6] = dif(crd_s1[7], crd_s1[5]) * dif(crd_s1[2], crd_s1[6]);
		op_c[7] = dif(crd_s1[6], crd_s1[4]) * dif(crd_s1[3], crd_s1[7]);
		ab_c[0] = dif(crd_s1[3], crd_s1[1]);
		ab_c[1] = dif(crd_s1[0], crd_s1[2]);
		ab_c[2] = dif(crd_s1[7], crd_s1[5]);
		ab_c[3] = dif(crd_s1[4], crd_s1[6]);
		cp_c[0] = ab_c[0] * crd_s1[0];
		cp_c[1] = ab_c[1] * crd_s1[1];
		cp_c[2] = ab_c[2] * crd_s1[4];
		cp_c[3] = ab_c[3] * crd_s1[5];
		dp_c[0] = ab_c[0] * ab_c[3];
		dp_c[1] = ab_c[2] * ab_c[1];
		on_c[0] = onseg(crd_s1[0], crd_s1[1], crd_s1[4], crd_s1[5], crd_s1[2], crd_s1[3]);
		on_c[1] = onseg(crd_s1[0], crd_s1[1], crd_s1[6], crd_s1[7], crd_s1[2], crd_s1[3]);
		on_c[2] = onseg(crd_s1[4], crd_s1[5], crd_s1[0], crd_s1[1], crd_s1[6], crd_s1[7]);
		on_c[3] = onseg(crd_s1[4], crd_s1[5], crd_s1[2], crd_s1[3], crd_s1[6], crd_s1[7]);
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			crd_s2 <= crd_s1;
			op_s2  <= op_c;
			ab_s2  <= ab_c;
			cp_s2  <= cp_c;
			dp_s2  <= dp_c;
			on_s2  <= on_c;
		end
	end

	// Stage 3: orientation codes, line constants, determinant
	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			for (int k = 0; k < 4; k++) begin
				ori_s3[k] <= ori(OW'(op_s2[2*k]) - OW'(op_s2[2*k+1]));
			end
			c1_s3  <= CCW'(cp_s2[0]) + CCW'(cp_s2[1]);
			c2_s3  <= CCW'(cp_s2[2]) + CCW'(cp_s2[3]);
			det_s3 <= DTW'(dp_s2[0]) - DTW'(dp_s2[1]);
			ab_s3  <= ab_s2;
			on_s3  <= on_s2;
			crd_s3 <= crd_s2;
		end
	end

	// Stage 4: classification and split numerator multiplies
	always_comb begin
		gen_c  = (ori_s3[0] != ori_s3[1]) && (ori_s3[2] != ori_s3[3]);
		side_c = '0;
		if (gen_c) begin
			side_c.hit      = 1'b1;
			side_c.hit_kind = segi_pkg::KIND_GEN;
		end else if (ori_s3[0] == segi_pkg::ORI_COL && on_s3[0]) begin
			side_c.hit      = 1'b1;
			side_c.hit_kind = segi_pkg::KIND_COL;
			side_c.point_x  = scale_sat(crd_s3[4]);
			side_c.point_y  = scale_sat(crd_s3[5]);
		end else if (ori_s3[1] == segi_pkg::ORI_COL && on_s3[1]) begin
			side_c.hit      = 1'b1;
			side_c.hit_kind = segi_pkg::KIND_COL;
			side_c.point_x  = scale_sat(crd_s3[6]);
			side_c.point_y  = scale_sat(crd_s3[7]);
		end else if (ori_s3[2] == segi_pkg::ORI_COL && on_s3[2]) begin
			side_c.hit      = 1'b1;
			side_c.hit_kind = segi_pkg::KIND_COL;
			side_c.point_x  = scale_sat(crd_s3[0]);
			side_c.point_y  = scale_sat(crd_s3[1]);
		end else if (ori_s3[3] == segi_pkg::ORI_COL && on_s3[3]) begin
			side_c.hit      = 1'b1;
			side_c.hit_kind = segi_pkg::KIND_COL;
			side_c.point_x  = scale_sat(crd_s3[2]);
			side_c.point_y  = scale_sat(crd_s3[3]);
		end
		// b2*c1, b1*c2, a1*c2, a2*c1 as low and high halves of c
		pp_c[0] = ab_s3[3] * $signed({1'b0, c1_s3[L-1:0]});
		pp_c[1] = ab_s3[3] * $signed(c1_s3[CCW-1:L]);
		pp_c[2] = ab_s3[1] * $signed({1'b0, c2_s3[L-1:0]});
		pp_c[3] = ab_s3[1] * $signed(c2_s3[CCW-1:L]);
		pp_c[4] = ab_s3[0] * $signed({1'b0, c2_s3[L-1:0]});
		pp_c[5] = ab_s3[0] * $signed(c2_s3[CCW-1:L]);
		pp_c[6] = ab_s3[2] * $signed({1'b0, c1_s3[L-1:0]});
		pp_c[7] = ab_s3[2] * $signed(c1_s3[CCW-1:L]);
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			gen_s4  <= gen_c;
			side_s4 <= side_c;
			det_s4  <= det_s3;
			pp_s4   <= pp_c;
		end
	end

	// Stage 5: recombine partial products
	always_ff @(posedge clk) begin
		if (adv_s5 && v_s4) begin
			for (int k = 0; k < 4; k++) begin
				fp_s5[k] <= (NPW'(pp_s4[2*k+1]) <<< L) + NPW'(pp_s4[2*k]);
			end
			gen_s5  <= gen_s4;
			side_s5 <= side_s4;
			det_s5  <= det_s4;
		end
	end

	// Stage 6: Cramer numerators scaled by the fraction
	always_ff @(posedge clk) begin
		if (adv_s6 && v_s5) begin
			nx_s6   <= (NW'(fp_s5[0]) - NW'(fp_s5[1])) <<< F;
			ny_s6   <= (NW'(fp_s5[2]) - NW'(fp_s5[3])) <<< F;
			gen_s6  <= gen_s5;
			side_s6 <= side_s5;
			det_s6  <= det_s5;
		end
	end

	// Stage 7: magnitudes and quotient signs
	always_comb begin
		mx_c = nx_s6[NW-1] ? NW'(-nx_s6) : NW'(nx_s6);
		my_c = ny_s6[NW-1] ? NW'(-ny_s6) : NW'(ny_s6);
		md_c = det_s6[DTW-1] ? DTW'(-det_s6) : DTW'(det_s6);
	end

	always_ff @(posedge clk) begin
		if (adv_s7 && v_s6) begin
			mx_s7          <= RW'(mx_c);
			my_s7          <= RW'(my_c);
			md_s7          <= md_c;
			ctl_s7.neg_x   <= nx_s6[NW-1] ^ det_s6[DTW-1];
			ctl_s7.neg_y   <= ny_s6[NW-1] ^ det_s6[DTW-1];
			ctl_s7.use_div <= gen_s6 && (det_s6 != '0);
			ctl_s7.side    <= side_s6;
		end
	end

	segi_div #(
		.RW(RW),
		.DW(DTW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (v_s7),
		.ent_stall (div_stall),
		.num_x     (mx_s7),
		.num_y     (my_s7),
		.den       (md_s7),
		.ctl       (ctl_s7),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// A miss carries no kind and no point
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.hit_kind == segi_pkg::KIND_NONE &&
			res.point_x == '0 && res.point_y == '0)
		else $error("miss word with kind or point set");

	// Any kind implies a hit
	a_kind_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit_kind != segi_pkg::KIND_NONE |-> res.hit)
		else $error("kind set without hit");

	// Input held off only when the first stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall |-> v_s1)
		else $error("input stalled with empty first stage");

endmodule
